/* rtl/kplc_pkg.sv */
// Package for the keypad PIN lock controller.
// Holds shared types, mode and key codes, register indexes and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kplc_pkg;

   // Digit buffer depth
   localparam int MAX_DIGITS   = 8;
   localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W       = $clog2(MAX_DIGITS);
   localparam int CMP_W        = (CNT_W > 4) ? CNT_W : 4;
   // The code register carries eight nibbles
   localparam int CODE_NIBBLES = 8;

   localparam int ELAPSED_W    = 20;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   // Result mode codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_ENTRY   = 3'd1;
   localparam logic [2:0] MODE_GRANTED = 3'd2;
   localparam logic [2:0] MODE_OPEN    = 3'd3;
   localparam logic [2:0] MODE_DENIED  = 3'd4;
   localparam logic [2:0] MODE_LOCKOUT = 3'd5;

   // Key codes
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_STAR      = 4'd10;
   localparam logic [3:0] KEY_HASH      = 4'd11;

   localparam logic [3:0] FAIL_MAX = 4'd15;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DIGITS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAILURES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TIMEOUT = 3'd5;

   typedef struct packed {
      logic [31:0]          code_digits;
      logic [3:0]           code_length;
      logic [3:0]           max_failures;
      logic [ELAPSED_W-1:0] idle_timeout_ms;
      logic [ELAPSED_W-1:0] lockout_ms;
      logic [ELAPSED_W-1:0] open_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic       key_valid;
      logic [3:0] key_code;
      logic       motion;
      logic       door_closed;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       bolt_locked;
      logic       green_lamp;
      logic       red_lamp;
      logic [3:0] digits_held;
      logic [3:0] failures;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/keypad_pin_lock_controller.sv */
// Top level of the keypad PIN lock controller: input word register, lock core,
// configuration bank and result word register.
// Depends on kplc_pkg, kplc_csr and kplc_core.
//
//   channel   ports                          direction  handshake
//   req       req_valid/ready + 4 fields     in         valid/ready
//   rsp       rsp_valid/ready + 6 fields     out        valid/ready
//   csr       csr_write_enable/index/wdata   in         write strobe, no wait
//
// One word per clock while the result register is free or draining; each word
// yields one result word, through the input register and then the result register.
// The lock state commits when a word moves from the input register to the
// result register, so back-to-back words each see their predecessor's update.
// A stalled result holds the result register; the input register still takes
// one more word, after which req_ready drops until rsp_ready returns.
// Synchronous active-high reset empties both registers and returns the lock
// to idle, disarmed, with zero digits, failures and elapsed time.
`timescale 1ns / 1ps
`default_nettype none

module keypad_pin_lock_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_key_valid,
   input  wire logic [3:0]                      req_key_code,
   input  wire logic                            req_motion,
   input  wire logic                            req_door_closed,
   // result words
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [2:0]                      rsp_mode,
   output      logic                            rsp_bolt_locked,
   output      logic                            rsp_green_lamp,
   output      logic                            rsp_red_lamp,
   output      logic [3:0]                      rsp_digits_held,
   output      logic [3:0]                      rsp_failures,
   // configuration
   input  wire logic                            csr_write_enable,
   input  wire logic [kplc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kplc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kplc_pkg::cfg_type cfg;
   kplc_pkg::req_type req_ff;
   kplc_pkg::rsp_type rsp_ff, result;
   logic              s1_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;
   logic              req_take;

   // word moves to the result register when that register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take)     s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance)        rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.key_valid   <= req_key_valid;
         req_ff.key_code    <= req_key_code;
         req_ff.motion      <= req_motion;
         req_ff.door_closed <= req_door_closed;
      end
      if (advance) rsp_ff <= result;
   end

   kplc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   kplc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = rsp_ff.mode;
   assign rsp_bolt_locked = rsp_ff.bolt_locked;
   assign rsp_green_lamp  = rsp_ff.green_lamp;
   assign rsp_red_lamp    = rsp_ff.red_lamp;
   assign rsp_digits_held = rsp_ff.digits_held;
   assign rsp_failures    = rsp_ff.failures;

endmodule

`default_nettype wire

/* rtl/kplc_csr.sv */
// Configuration register bank for the keypad PIN lock controller.
// Depends on kplc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kplc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [kplc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [kplc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output kplc_pkg::cfg_type                       cfg
);

   kplc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_digits     <= 32'd0;
         cfg_ff.code_length     <= 4'd4;
         cfg_ff.max_failures    <= 4'd3;
         cfg_ff.idle_timeout_ms <= 20'd10000;
         cfg_ff.lockout_ms      <= 20'd30000;
         cfg_ff.open_timeout_ms <= 20'd30000;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            kplc_pkg::CSR_CODE_DIGITS:  cfg_ff.code_digits     <= csr_wdata;
            kplc_pkg::CSR_CODE_LENGTH:  cfg_ff.code_length     <= csr_wdata[3:0];
            kplc_pkg::CSR_MAX_FAILURES: cfg_ff.max_failures    <= csr_wdata[3:0];
            kplc_pkg::CSR_IDLE_TIMEOUT:
               cfg_ff.idle_timeout_ms <= csr_wdata[kplc_pkg::ELAPSED_W-1:0];
            kplc_pkg::CSR_LOCKOUT:
               cfg_ff.lockout_ms      <= csr_wdata[kplc_pkg::ELAPSED_W-1:0];
            kplc_pkg::CSR_OPEN_TIMEOUT:
               cfg_ff.open_timeout_ms <= csr_wdata[kplc_pkg::ELAPSED_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/kplc_core.sv */
// Lock state machine, digit buffer and timers of the keypad PIN lock controller.
// Computes the post-update result combinationally; commits state on step.
// Depends on kplc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kplc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire kplc_pkg::req_type item,
   input  wire kplc_pkg::cfg_type cfg,
   output kplc_pkg::rsp_type      result
);

   typedef enum logic [2:0] {
      M_IDLE    = kplc_pkg::MODE_IDLE,
      M_ENTRY   = kplc_pkg::MODE_ENTRY,
      M_GRANTED = kplc_pkg::MODE_GRANTED,
      M_OPEN    = kplc_pkg::MODE_OPEN,
      M_DENIED  = kplc_pkg::MODE_DENIED,
      M_LOCKOUT = kplc_pkg::MODE_LOCKOUT
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic                              armed_ff, armed_in;
   logic [kplc_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [3:0]                        fail_ff, fail_in;
   logic [kplc_pkg::ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic [kplc_pkg::ELAPSED_W-1:0]    tick;
   logic [3:0]                        store_ff [kplc_pkg::MAX_DIGITS];
   logic                              wr_en;
   logic                              match;
   logic                              unlocked;

   // saturating millisecond count
   assign tick = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   // entry compare: length, then each held digit against its code nibble
   always_comb begin
      match = (kplc_pkg::CMP_W'(count_ff) == kplc_pkg::CMP_W'(cfg.code_length));
      for (int i = 0; i < kplc_pkg::MAX_DIGITS; i++) begin
         if (kplc_pkg::CNT_W'(i) < count_ff) begin
            if (i >= kplc_pkg::CODE_NIBBLES) begin
               match = 1'b0;
            end else if (store_ff[i] !=
                         cfg.code_digits[4 * (i % kplc_pkg::CODE_NIBBLES) +: 4]) begin
               match = 1'b0;
            end
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      fail_in    = fail_ff;
      elapsed_in = elapsed_ff;
      wr_en      = 1'b0;
      unique case (mode_ff)
         M_IDLE: begin
            if (!armed_ff) begin
               if (!item.motion) armed_in = 1'b1;
            end else if (item.motion) begin
               mode_in    = M_ENTRY;
               elapsed_in = '0;
               count_in   = '0;
            end
         end
         M_ENTRY: begin
            elapsed_in = tick;
            if (tick > cfg.idle_timeout_ms) begin
               mode_in  = M_IDLE;
               count_in = '0;
            end else if (item.key_valid) begin
               elapsed_in = '0;
               unique case (item.key_code)
                  kplc_pkg::KEY_HASH: begin
                     count_in = '0;
                     if (match) begin
                        fail_in = '0;
                        mode_in = M_GRANTED;
                     end else begin
                        if (fail_ff != kplc_pkg::FAIL_MAX) fail_in = fail_ff + 1'b1;
                        mode_in = M_DENIED;
                     end
                  end
                  kplc_pkg::KEY_STAR: count_in = '0;
                  default: begin
                     // letters only restart the timer
                     if (item.key_code <= kplc_pkg::KEY_DIGIT_MAX &&
                         count_ff < kplc_pkg::CNT_W'(kplc_pkg::MAX_DIGITS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         M_GRANTED: begin
            mode_in    = M_OPEN;
            elapsed_in = '0;
         end
         M_OPEN: begin
            elapsed_in = tick;
            if (item.door_closed || tick > cfg.open_timeout_ms) mode_in = M_IDLE;
         end
         M_DENIED: begin
            elapsed_in = '0;
            if (fail_ff >= cfg.max_failures) begin
               mode_in = M_LOCKOUT;
            end else begin
               mode_in  = M_ENTRY;
               count_in = '0;
            end
         end
         M_LOCKOUT: begin
            elapsed_in = tick;
            if (tick >= cfg.lockout_ms) begin
               fail_in = '0;
               mode_in = M_IDLE;
            end
         end
         default: mode_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_IDLE;
         armed_ff   <= 1'b0;
         count_ff   <= '0;
         fail_ff    <= '0;
         elapsed_ff <= '0;
      end else if (step) begin
         mode_ff    <= mode_in;
         armed_ff   <= armed_in;
         count_ff   <= count_in;
         fail_ff    <= fail_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // digit buffer, written at the current count
   always_ff @(posedge clock) begin
      if (step && wr_en) store_ff[count_ff[kplc_pkg::ADDR_W-1:0]] <= item.key_code;
   end

   assign unlocked = (mode_in == M_GRANTED) || (mode_in == M_OPEN);

   always_comb begin
      result.mode        = mode_in;
      result.bolt_locked = !unlocked;
      result.green_lamp  = unlocked;
      result.red_lamp    = (mode_in == M_LOCKOUT);
      result.digits_held = 4'(count_in);
      result.failures    = fail_in;
   end

endmodule

`default_nettype wire

/* rtl/kplc_checker.sv */
// Port-level checks for the keypad PIN lock controller, bound to the top level.
// Depends on kplc_pkg and keypad_pin_lock_controller.
`timescale 1ns / 1ps
`default_nettype none

module kplc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_mode,
   input wire logic       rsp_bolt_locked,
   input wire logic       rsp_green_lamp,
   input wire logic       rsp_red_lamp,
   input wire logic [3:0] rsp_digits_held,
   input wire logic [3:0] rsp_failures
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode) &&
      $stable(rsp_failures) && $stable(rsp_digits_held))
      else $error("result word changed while stalled");

   // bolt and green lamp are complementary and follow the unlocked modes
   a_unlock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bolt_locked == !rsp_green_lamp) &&
      (rsp_green_lamp == (rsp_mode == kplc_pkg::MODE_GRANTED ||
                          rsp_mode == kplc_pkg::MODE_OPEN)))
      else $error("bolt/lamp disagree with mode");

   a_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_lamp == (rsp_mode == kplc_pkg::MODE_LOCKOUT))
      else $error("red lamp disagrees with lockout mode");

   // digits are only held while entering
   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != kplc_pkg::MODE_ENTRY |-> rsp_digits_held == 4'd0)
      else $error("digits held outside entry");

   // a grant always clears the failure count
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == kplc_pkg::MODE_GRANTED |-> rsp_failures == 4'd0)
      else $error("failures not cleared on grant");

endmodule

bind keypad_pin_lock_controller kplc_checker u_kplc_checker (.*);

`default_nettype wire
